FILE: hw/rtl/ccas_pkg.sv
`timescale 1ns / 1ps

package ccas_pkg;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_FIRST = 8'd32;
    localparam logic [7:0] CHAR_LAST  = 8'd127;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;

    localparam logic [1:0] STAT_NONE = 2'd0;
    localparam logic [1:0] STAT_OK   = 2'd1;
    localparam logic [1:0] STAT_FMT  = 2'd2;
    localparam logic [1:0] STAT_DAY  = 2'd3;

    localparam int DEC_LEN = 19;

    localparam logic [15:0] MAX_HOUR   = 16'd23;
    localparam logic [15:0] MAX_MINSEC = 16'd59;
    localparam logic [15:0] MAX_MONTH  = 16'd12;
    localparam logic [15:0] MAX_YEAR   = 16'd3000;

    localparam logic [4:0] MONTH_LEN [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                             5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};
    localparam logic [4:0] DEFAULT_MONTH_LEN = 5'd31;

    localparam int LED_STEPS = 7;
    localparam logic [3:0] LED_PATTERN [LED_STEPS] = '{4'd1, 4'd3, 4'd7, 4'd15,
                                                      4'd14, 4'd12, 4'd8};
    localparam logic [3:0] LED_ALL_ON = 4'd15;

    typedef struct packed {
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } time_t;

    localparam time_t TIME_RESET = '{hours: 5'd0, minutes: 6'd0, seconds: 6'd1,
                                     day: 5'd0, month: 4'd0, year: 12'd0};

    typedef struct packed {
        logic [1:0] status;
        logic       set_ok;
        time_t      tm;
    } dec_t;

    typedef struct packed {
        time_t      tm;
        logic       rollover;
        logic [2:0] step;
        logic [3:0] led;
    } tick_t;

    // first member sits in the top bits: status ends up in bits [1:0]
    typedef struct packed {
        logic        rollover;
        logic [3:0]  led_bar;
        logic [11:0] year_value;
        logic [3:0]  month_number;
        logic [4:0]  day_of_month;
        logic [5:0]  seconds;
        logic [5:0]  minutes;
        logic [4:0]  hours;
        logic        running;
        logic [1:0]  status;
    } out_t;

    localparam int OUT_W   = $bits(out_t);
    localparam int TDATA_W = ((OUT_W + 7) / 8) * 8;

    function automatic logic [4:0] month_days(input logic [3:0] month);
        logic [4:0] len;
        len = DEFAULT_MONTH_LEN;
        if (month >= 4'd1 && month <= 4'd12)
        begin
            len = MONTH_LEN[4'(month - 4'd1)];
        end
        return len;
    endfunction

    function automatic logic [15:0] digit(input logic [7:0] chr);
        return 16'(chr) - 16'(CHAR_ZERO);
    endfunction

endpackage

FILE: hw/rtl/ccas_line_dec.sv
`timescale 1ns / 1ps

module ccas_line_dec (
    input  logic [7:0]      line [ccas_pkg::DEC_LEN],
    output ccas_pkg::dec_t  dec
);

    logic [15:0] hr;
    logic [15:0] mi;
    logic [15:0] se;
    logic [15:0] dy;
    logic [15:0] mo;
    logic [15:0] yr;
    logic        fmt_bad;
    logic        day_bad;

    always_comb
    begin
        hr = ccas_pkg::digit(line[0]) * 16'd10 + ccas_pkg::digit(line[1]);
        mi = ccas_pkg::digit(line[3]) * 16'd10 + ccas_pkg::digit(line[4]);
        se = ccas_pkg::digit(line[6]) * 16'd10 + ccas_pkg::digit(line[7]);
        dy = ccas_pkg::digit(line[9]) * 16'd10 + ccas_pkg::digit(line[10]);
        mo = ccas_pkg::digit(line[12]) * 16'd10 + ccas_pkg::digit(line[13]);
        yr = ccas_pkg::digit(line[15]) * 16'd1000 + ccas_pkg::digit(line[16]) * 16'd100
           + ccas_pkg::digit(line[17]) * 16'd10 + ccas_pkg::digit(line[18]);

        fmt_bad = (hr > ccas_pkg::MAX_HOUR) || (mi > ccas_pkg::MAX_MINSEC)
               || (se > ccas_pkg::MAX_MINSEC) || (mo == 16'd0)
               || (mo > ccas_pkg::MAX_MONTH) || (yr > ccas_pkg::MAX_YEAR);
        day_bad = (dy == 16'd0) || (dy > 16'(ccas_pkg::month_days(mo[3:0])));

        dec = '0;
        if (fmt_bad)
        begin
            dec.status = ccas_pkg::STAT_FMT;
        end
        else if (day_bad)
        begin
            dec.status = ccas_pkg::STAT_DAY;
        end
        else
        begin
            dec.status     = ccas_pkg::STAT_OK;
            dec.set_ok     = 1'b1;
            dec.tm.hours   = hr[4:0];
            dec.tm.minutes = mi[5:0];
            dec.tm.seconds = se[5:0];
            dec.tm.day     = dy[4:0];
            dec.tm.month   = mo[3:0];
            dec.tm.year    = yr[11:0];
        end
    end

endmodule

FILE: hw/rtl/ccas_tick.sv
`timescale 1ns / 1ps

module ccas_tick (
    input  ccas_pkg::time_t cur,
    input  logic [2:0]      step,
    output ccas_pkg::tick_t res
);

    logic [6:0] sec;
    logic [6:0] mins;
    logic [5:0] hr;
    logic [5:0] dy;
    logic [4:0] mon;
    logic [3:0] step_inc;

    always_comb
    begin
        sec      = 7'(cur.seconds) + 7'd1;
        mins     = 7'(cur.minutes) + 7'd1;
        hr       = 6'(cur.hours) + 6'd1;
        dy       = 6'(cur.day) + 6'd1;
        mon      = 5'(cur.month) + 5'd1;
        step_inc = 4'(step) + 4'd1;

        res          = '0;
        res.tm       = cur;
        res.tm.seconds = sec[5:0];
        if (sec >= 7'd60)
        begin
            res.tm.seconds = '0;
            res.tm.minutes = mins[5:0];
            if (mins >= 7'd60)
            begin
                res.tm.minutes = '0;
                res.tm.hours   = hr[4:0];
                if (hr >= 6'd24)
                begin
                    res.tm.hours = '0;
                    res.rollover = 1'b1;
                    res.tm.day   = dy[4:0];
                    if (dy > 6'(ccas_pkg::month_days(cur.month)))
                    begin
                        res.tm.day   = 5'd1;
                        res.tm.month = (mon >= 5'd13) ? 4'd1 : mon[3:0];
                    end
                end
            end
        end

        res.led  = ccas_pkg::LED_PATTERN[(step < 3'(ccas_pkg::LED_STEPS)) ? step : 3'd0];
        res.step = (step_inc >= 4'(ccas_pkg::LED_STEPS)) ? 3'd0 : step_inc[2:0];
    end

endmodule

FILE: hw/rtl/calendar_clock_with_ascii_set.sv
`timescale 1ns / 1ps

// channel   | signals                     | contents
// ----------+-----------------------------+---------------------------------------
// input     | s_tvalid s_tready s_tdata   | tdata: rx_byte; tuser: command
//           | s_tuser                     |
// output    | m_tvalid m_tready m_tdata   | status, running, time, led_bar,
//           |                             | day_rollover
//
// One result beat per input beat; m_tvalid rises from the result register.
// Without an m_tready stall a new beat can be taken every cycle; the input and the
// result register are the only stages, all decode and counting sits between them.
// rst_n clears the line buffer, counters and both valid bits; time is preset.
// A stall on m_tready holds the result; the input stage still fills once.

module calendar_clock_with_ascii_set #(
    parameter int LINE_DEPTH = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,  // [7:0] rx_byte
    input  logic [0:0]                   s_tuser,  // [0] command
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [1:0] status, [2] running, [7:3] hours, [13:8] minutes, [19:14] seconds,
    // [24:20] day_of_month, [28:25] month_number, [40:29] year_value,
    // [44:41] led_bar, [45] day_rollover, [47:46] zero
    output logic [ccas_pkg::TDATA_W-1:0] m_tdata
);

    localparam int PW = $clog2(LINE_DEPTH);

    logic                   in_valid_reg;
    logic                   in_cmd_reg;
    logic [7:0]             in_byte_reg;
    logic                   m_valid_reg;
    ccas_pkg::out_t         m_data_reg;

    logic [7:0]             line_buf_reg  [LINE_DEPTH];
    logic [7:0]             line_buf_next [LINE_DEPTH];
    logic [PW-1:0]          pos_reg;
    logic [PW-1:0]          pos_next;
    ccas_pkg::time_t        time_reg;
    ccas_pkg::time_t        time_next;
    logic                   running_reg;
    logic                   running_next;
    logic [2:0]             led_step_reg;
    logic [2:0]             led_step_next;
    logic [3:0]             led_shown_reg;
    logic [3:0]             led_shown_next;

    logic [7:0]             dec_line [ccas_pkg::DEC_LEN];
    ccas_pkg::dec_t         dec;
    ccas_pkg::tick_t        tick;
    ccas_pkg::out_t         result;
    logic                   out_adv;
    logic                   fire;

    assign out_adv  = !m_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_adv;
    assign fire     = in_valid_reg && out_adv;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(ccas_pkg::TDATA_W - ccas_pkg::OUT_W){1'b0}}, m_data_reg};

    always_comb
    begin
        for (int i = 0; i < ccas_pkg::DEC_LEN; i++)
        begin
            dec_line[i] = line_buf_reg[i];
        end
    end

    ccas_line_dec u_dec (
        .line (dec_line),
        .dec  (dec)
    );

    ccas_tick u_tick (
        .cur  (time_reg),
        .step (led_step_reg),
        .res  (tick)
    );

    always_comb
    begin
        line_buf_next  = line_buf_reg;
        pos_next       = pos_reg;
        time_next      = time_reg;
        running_next   = running_reg;
        led_step_next  = led_step_reg;
        led_shown_next = led_shown_reg;
        result         = '0;

        if (in_cmd_reg == ccas_pkg::CMD_TICK)
        begin
            if (running_reg)
            begin
                time_next       = tick.tm;
                led_step_next   = tick.step;
                led_shown_next  = tick.led;
                result.rollover = tick.rollover;
            end
        end
        else if (in_byte_reg == ccas_pkg::CHAR_CR)
        begin
            result.status = dec.status;
            time_next     = dec.tm;
            if (dec.set_ok)
            begin
                running_next = 1'b1;
            end
            for (int i = 0; i < LINE_DEPTH; i++)
            begin
                line_buf_next[i] = '0;
            end
            pos_next = '0;
        end
        else if (in_byte_reg inside {[ccas_pkg::CHAR_FIRST:ccas_pkg::CHAR_LAST]})
        begin
            line_buf_next[pos_reg] = in_byte_reg;
            pos_next = (pos_reg == PW'(LINE_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
        end

        result.running      = running_next;
        result.hours        = time_next.hours;
        result.minutes      = time_next.minutes;
        result.seconds      = time_next.seconds;
        result.day_of_month = time_next.day;
        result.month_number = time_next.month;
        result.year_value   = time_next.year;
        result.led_bar      = led_shown_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < LINE_DEPTH; i++)
            begin
                line_buf_reg[i] <= '0;
            end
            pos_reg       <= '0;
            time_reg      <= ccas_pkg::TIME_RESET;
            running_reg   <= 1'b0;
            led_step_reg  <= '0;
            led_shown_reg <= ccas_pkg::LED_ALL_ON;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_adv)
            begin
                m_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                line_buf_reg  <= line_buf_next;
                pos_reg       <= pos_next;
                time_reg      <= time_next;
                running_reg   <= running_next;
                led_step_reg  <= led_step_next;
                led_shown_reg <= led_shown_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg  <= s_tuser[0];
            in_byte_reg <= s_tdata;
        end
        if (fire)
        begin
            m_data_reg <= result;
        end
    end

endmodule

FILE: hw/rtl/ccas_chk.sv
`timescale 1ns / 1ps

module ccas_chk (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [ccas_pkg::TDATA_W-1:0] m_tdata
);

    ccas_pkg::out_t res;

    assign res = m_tdata[ccas_pkg::OUT_W-1:0];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_set_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.status == ccas_pkg::STAT_OK
        |-> res.running && res.month_number != 4'd0 && res.day_of_month != 5'd0)
        else $error("accepted time without running clock");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (res.status == ccas_pkg::STAT_FMT || res.status == ccas_pkg::STAT_DAY)
        |-> res.hours == 5'd0 && res.minutes == 6'd0 && res.seconds == 6'd0
            && res.day_of_month == 5'd0 && res.month_number == 4'd0
            && res.year_value == 12'd0)
        else $error("time not cleared on decode error");

    a_rollover: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.rollover
        |-> res.running && res.status == ccas_pkg::STAT_NONE && res.hours == 5'd0
            && res.minutes == 6'd0 && res.seconds == 6'd0)
        else $error("day rollover without midnight");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> res.led_bar != 4'd0 && res.hours <= 5'd23
            && res.minutes <= 6'd59 && res.seconds <= 6'd59)
        else $error("time or led bar out of range");

endmodule

bind calendar_clock_with_ascii_set ccas_chk u_ccas_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
